@@ hdl/rgbaover_pkg.sv @@
// ---------------------------------------------------------------------------
// rgbaover_pkg
// Shared types and constants for the RGBA8 over-compositing pipeline.
// ---------------------------------------------------------------------------
package rgbaover_pkg;

	localparam int PIX_W       = 8;
	localparam int NUM_CH      = 3;   // red, green, blue
	localparam int AL_W        = 16;  // total weight, at most 255*255
	localparam int NUM_W       = 24;  // blend numerator, below 256*al
	localparam int PROD_W      = 32;  // al times reciprocal of 255
	localparam int DIV_STEPS   = 2;   // quotient bits resolved per divider stage
	localparam int DIV_STAGES  = PIX_W / DIV_STEPS;

	localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [PIX_W-1:0] ALPHA_CLEAR  = 8'd0;

	// al/255 == (al * RECIP_255) >> RECIP_SHIFT, exact for any 16-bit al
	localparam logic [AL_W-1:0] RECIP_255   = 16'd32897;
	localparam int              RECIP_SHIFT = 23;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] alpha;
	} pixel_t;

	// per-stage control that travels with each request
	typedef struct packed {
		logic valid;
		logic bypass;
	} pipe_ctl_t;

	typedef logic [NUM_CH-1:0][NUM_W-1:0] num_vec_t;
	typedef logic [NUM_CH-1:0][PIX_W-1:0] col_vec_t;

endpackage

@@ hdl/rgbaover_weight.sv @@
// ---------------------------------------------------------------------------
// rgbaover_weight
// Three pipeline stages: alpha weights, channel products, blend numerators
// and the composited alpha product.
// ---------------------------------------------------------------------------
module rgbaover_weight import rgbaover_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  pixel_t              src,
	input  pixel_t              dst,
	output pipe_ctl_t           ctl_s3,
	output pixel_t              pass_s3,
	output num_vec_t            num_s3,
	output logic [AL_W-1:0]     al_s3,
	output logic [PROD_W-1:0]   alpha_prod_s3
);

	pipe_ctl_t              ctl_s1, ctl_s2;
	pixel_t                 pass_s1, pass_s2;
	col_vec_t               src_col_s1, dst_col_s1;
	logic [AL_W-1:0]        u_s1, v_s1, al_s2;
	num_vec_t               prod_s_s2, prod_d_s2;

	pipe_ctl_t              ctl_in;
	pixel_t                 pass_in;
	col_vec_t               src_col, dst_col;
	logic [PIX_W-1:0]       inv_a;
	logic [AL_W-1:0]        u_in, v_in;

	// stage 1 inputs: special cases and the two alpha weights
	always_comb begin
		ctl_in.valid  = in_valid;
		ctl_in.bypass = (src.alpha == ALPHA_OPAQUE) || (src.alpha == ALPHA_CLEAR) ||
		                (dst.alpha == ALPHA_CLEAR);
		pass_in       = (src.alpha == ALPHA_CLEAR) ? dst : src;
		inv_a         = ALPHA_OPAQUE - src.alpha;
		u_in          = {src.alpha, 8'h00} - {8'h00, src.alpha};
		v_in          = AL_W'(inv_a) * AL_W'(dst.alpha);
		src_col[CH_RED]   = src.red;
		src_col[CH_GREEN] = src.green;
		src_col[CH_BLUE]  = src.blue;
		dst_col[CH_RED]   = dst.red;
		dst_col[CH_GREEN] = dst.green;
		dst_col[CH_BLUE]  = dst.blue;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			pass_s1    <= pass_in;
			src_col_s1 <= src_col;
			dst_col_s1 <= dst_col;
			u_s1       <= u_in;
			v_s1       <= v_in;
			// stage 2: total weight and channel products
			pass_s2    <= pass_s1;
			al_s2      <= u_s1 + v_s1;
			for (int c = 0; c < NUM_CH; c++) begin
				prod_s_s2[c] <= NUM_W'(src_col_s1[c]) * NUM_W'(u_s1);
				prod_d_s2[c] <= NUM_W'(dst_col_s1[c]) * NUM_W'(v_s1);
			end
			// stage 3: numerators and alpha reciprocal product
			pass_s3       <= pass_s2;
			al_s3         <= al_s2;
			alpha_prod_s3 <= PROD_W'(al_s2) * PROD_W'(RECIP_255);
			for (int c = 0; c < NUM_CH; c++) begin
				num_s3[c] <= prod_s_s2[c] + prod_d_s2[c];
			end
		end
	end

	// a blended request always has a total weight of at least 255
	a_weight_floor: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s2.valid && !ctl_s2.bypass |-> al_s2 >= AL_W'(ALPHA_OPAQUE))
		else $error("blend weight below 255");

endmodule

@@ hdl/rgbaover_div_stage.sv @@
// ---------------------------------------------------------------------------
// rgbaover_div_stage
// One stage of the restoring divider: resolves two quotient bits of each
// colour channel and forwards the rest of the request.
// ---------------------------------------------------------------------------
module rgbaover_div_stage import rgbaover_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  pipe_ctl_t           ctl_in,
	input  pixel_t              pass_in,
	input  logic [AL_W-1:0]     al_in,
	input  logic [PIX_W-1:0]    alpha_in,
	input  num_vec_t            rem_in,
	input  col_vec_t            quo_in,
	output pipe_ctl_t           ctl_q,
	output pixel_t              pass_q,
	output logic [AL_W-1:0]     al_q,
	output logic [PIX_W-1:0]    alpha_q,
	output num_vec_t            rem_q,
	output col_vec_t            quo_q
);

	logic [NUM_W-1:0]   dvs;
	logic [NUM_W:0]     shifted;
	num_vec_t           rem_nxt;
	col_vec_t           quo_nxt;

	// shift-and-subtract against al scaled to the numerator's top byte
	always_comb begin
		dvs     = {al_in, 8'h00};
		rem_nxt = rem_in;
		quo_nxt = quo_in;
		shifted = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				shifted = {rem_nxt[c], 1'b0};
				if (shifted >= {1'b0, dvs}) begin
					shifted    = shifted - {1'b0, dvs};
					quo_nxt[c] = {quo_nxt[c][PIX_W-2:0], 1'b1};
				end else begin
					quo_nxt[c] = {quo_nxt[c][PIX_W-2:0], 1'b0};
				end
				rem_nxt[c] = shifted[NUM_W-1:0];
			end
		end
	end

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (en) begin
			pass_q  <= pass_in;
			al_q    <= al_in;
			alpha_q <= alpha_in;
			rem_q   <= rem_nxt;
			quo_q   <= quo_nxt;
		end
	end

	// partial remainder of a blended request stays below the scaled divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.valid && !ctl_q.bypass |->
			rem_q[CH_RED] < {al_q, 8'h00} && rem_q[CH_GREEN] < {al_q, 8'h00} &&
			rem_q[CH_BLUE] < {al_q, 8'h00})
		else $error("divider remainder out of range");

endmodule

@@ hdl/rgba8_alpha_blend_over_unit.sv @@
// ---------------------------------------------------------------------------
// rgba8_alpha_blend_over_unit
// Porter-Duff over of a straight-alpha RGBA8 source pixel onto a
// straight-alpha RGBA8 destination pixel, fully pipelined.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | src_red..src_alpha, dst_red..dst_alpha
//  output   | out_valid / out_ready| out_red, out_green, out_blue, out_alpha
//
// Three weight/product stages come first, then four divider stages
// of two quotient bits each; the last divider register is the output register.
// One request is accepted per cycle while the output is not stalled; the weight and divider stages set the latency.
// A stalled output freezes all stages together, so nothing is lost or repeated.
// Reset clears the stage control bits only; the payload registers are not reset.
// ---------------------------------------------------------------------------
module rgba8_alpha_blend_over_unit import rgbaover_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  src_red,
	input  logic [7:0]  src_green,
	input  logic [7:0]  src_blue,
	input  logic [7:0]  src_alpha,
	input  logic [7:0]  dst_red,
	input  logic [7:0]  dst_green,
	input  logic [7:0]  dst_blue,
	input  logic [7:0]  dst_alpha,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha
);

	logic                   en;
	pixel_t                 src, dst;
	pipe_ctl_t              ctl_s3;
	pixel_t                 pass_s3;
	num_vec_t               num_s3;
	logic [AL_W-1:0]        al_s3;
	logic [PROD_W-1:0]      alpha_prod_s3;

	pipe_ctl_t              div_ctl   [DIV_STAGES+1];
	pixel_t                 div_pass  [DIV_STAGES+1];
	logic [AL_W-1:0]        div_al    [DIV_STAGES+1];
	logic [PIX_W-1:0]       div_alpha [DIV_STAGES+1];
	num_vec_t               div_rem   [DIV_STAGES+1];
	col_vec_t               div_quo   [DIV_STAGES+1];

	pipe_ctl_t              ctl_out;
	pixel_t                 pass_out;
	col_vec_t               quo_out;

	// whole pipe advances unless a finished request is held at the output
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	assign src = '{red: src_red, green: src_green, blue: src_blue, alpha: src_alpha};
	assign dst = '{red: dst_red, green: dst_green, blue: dst_blue, alpha: dst_alpha};

	// weights, products and numerators
	rgbaover_weight u_weight (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (in_valid),
		.src           (src),
		.dst           (dst),
		.ctl_s3        (ctl_s3),
		.pass_s3       (pass_s3),
		.num_s3        (num_s3),
		.al_s3         (al_s3),
		.alpha_prod_s3 (alpha_prod_s3)
	);

	// divider chain head
	assign div_ctl[0]   = ctl_s3;
	assign div_pass[0]  = pass_s3;
	assign div_al[0]    = al_s3;
	assign div_alpha[0] = alpha_prod_s3[RECIP_SHIFT +: PIX_W];
	assign div_rem[0]   = num_s3;
	assign div_quo[0]   = '0;

	// divider stages
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		rgbaover_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_in   (div_ctl[g]),
			.pass_in  (div_pass[g]),
			.al_in    (div_al[g]),
			.alpha_in (div_alpha[g]),
			.rem_in   (div_rem[g]),
			.quo_in   (div_quo[g]),
			.ctl_q    (div_ctl[g+1]),
			.pass_q   (div_pass[g+1]),
			.al_q     (div_al[g+1]),
			.alpha_q  (div_alpha[g+1]),
			.rem_q    (div_rem[g+1]),
			.quo_q    (div_quo[g+1])
		);
	end

	// output select: passed-through pixel or blended result
	assign ctl_out   = div_ctl[DIV_STAGES];
	assign pass_out  = div_pass[DIV_STAGES];
	assign quo_out   = div_quo[DIV_STAGES];
	assign out_valid = ctl_out.valid;
	assign out_red   = ctl_out.bypass ? pass_out.red   : quo_out[CH_RED];
	assign out_green = ctl_out.bypass ? pass_out.green : quo_out[CH_GREEN];
	assign out_blue  = ctl_out.bypass ? pass_out.blue  : quo_out[CH_BLUE];
	assign out_alpha = ctl_out.bypass ? pass_out.alpha : div_alpha[DIV_STAGES];

	// a held output result blocks new requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request accepted while output stalled");

	// an empty output stage never blocks the input
	a_empty_flows: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// a blended pixel never comes out fully transparent
	a_blend_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ctl_out.bypass |-> out_alpha != ALPHA_CLEAR)
		else $error("blended alpha is zero");

endmodule
